>>> rtl/core/bns_pkg.sv
// ----------------------------------------------------------------------------
// bns_pkg
// shared types, codes and defaults of the bigram name sampler
// ----------------------------------------------------------------------------
package bns_pkg;

    localparam int SYMBOLS_DEF         = 27;
    localparam int MAX_NAME_LENGTH_DEF = 8;

    localparam int LETTER_W = 5;
    localparam int SUM_W    = 16;
    localparam int RND_W    = 8;

    localparam logic       OP_WRITE    = 1'b0;
    localparam logic       OP_GENERATE = 1'b1;

    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_MIN_LENGTH  = 2'd0;
    localparam logic [1:0]  CFG_MAX_LENGTH  = 2'd1;
    localparam logic [1:0]  CFG_RETRY_LIMIT = 2'd2;

    localparam logic [3:0]  MIN_LENGTH_RST  = 4'd3;
    localparam logic [3:0]  MAX_LENGTH_RST  = 4'd8;
    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd255;
    localparam logic [7:0]  RNG_STATE_RST   = 8'h5A;

    typedef struct packed {
        logic       operation;
        logic [4:0] row;
        logic [4:0] column;
        logic [7:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [4:0] letter;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] min_length;
        logic [3:0] max_length;
        logic [7:0] retry_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_ADDR,
        ST_WALK,
        ST_DECIDE,
        ST_PUSH,
        ST_FLUSH
    } t_state;

endpackage

>>> rtl/core/bns_table.sv
// ----------------------------------------------------------------------------
// bns_table
// transition weight memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bns_table
    import bns_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEF,
    localparam int DEPTH  = SYMBOLS * SYMBOLS,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bns_rng.sv
// ----------------------------------------------------------------------------
// bns_rng
// 8-bit xorshift generator with a mixed-in step counter
// ----------------------------------------------------------------------------
module bns_rng
    import bns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    output logic [RND_W-1:0] o_value
);

    logic [RND_W-1:0] r_state, n_state;
    logic [RND_W-1:0] r_count, n_count;
    logic [RND_W-1:0] s1, s2, s3, s4;

    always_comb begin
        n_count = r_count + RND_W'(1);
        s1      = r_state ^ (r_state << 1);
        s2      = s1 ^ (s1 >> 1);
        s3      = s2 ^ (s2 << 2);
        s4      = s3 ^ n_count;
        n_state = (s4 == '0) ? RND_W'(1) : s4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RNG_STATE_RST;
            r_count <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_value = r_state;

endmodule

>>> rtl/core/bns_seq.sv
// ----------------------------------------------------------------------------
// bns_seq
// name sequencer: row walk over the table, retry control, result register
// ----------------------------------------------------------------------------
module bns_seq
    import bns_pkg::*;
#(
    parameter int SYMBOLS         = SYMBOLS_DEF,
    parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF,
    localparam int AW             = $clog2(SYMBOLS * SYMBOLS),
    localparam int SW             = $clog2(SYMBOLS),
    localparam int PW             = $clog2(MAX_NAME_LENGTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    output logic             o_tab_we,
    output logic [AW-1:0]    o_tab_waddr,
    output logic [7:0]       o_tab_wdata,
    output logic             o_tab_re,
    output logic [AW-1:0]    o_tab_raddr,
    input  logic [7:0]       i_tab_rdata,
    output logic             o_rng_step,
    input  logic [RND_W-1:0] i_rng_value
);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_base, n_base;
    logic [SW-1:0]    r_prev, n_prev;
    logic [SW-1:0]    r_k, n_k;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SW-1:0]    r_sym, n_sym;
    logic [SW-1:0]    r_pend, n_pend;
    logic [PW-1:0]    r_pos, n_pos;
    logic [7:0]       r_tries, n_tries;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             in_accept;
    logic             slot_free;
    logic [SUM_W-1:0] sum_n;
    logic             hit;
    logic             walk_done;
    logic [PW-1:0]    maxl_eff;
    logic [3:0]       minl_eff;
    logic [7:0]       retry_eff;
    logic             mandatory;
    logic [8:0]       tries_n;
    logic             retry_more;
    logic             is_term;
    logic [SW-1:0]    sym_final;
    logic [PW-1:0]    pos_n;
    logic             name_full;
    logic             can_push;
    logic [SW+4:0]    pend_ext;
    logic             wr_in_range;

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    assign sum_n     = r_sum + SUM_W'(i_tab_rdata);
    assign hit       = SUM_W'(i_rng_value) < sum_n;
    assign walk_done = hit || (r_k == SW'(SYMBOLS - 1));

    always_comb begin
        if (i_cfg.max_length == 4'd0) begin
            maxl_eff = PW'(1);
        end else if (32'(i_cfg.max_length) > MAX_NAME_LENGTH) begin
            maxl_eff = PW'(MAX_NAME_LENGTH);
        end else begin
            maxl_eff = PW'(i_cfg.max_length);
        end
    end

    assign minl_eff   = (i_cfg.min_length == 4'd0) ? 4'd1 : i_cfg.min_length;
    assign retry_eff  = (i_cfg.retry_limit == 8'd0) ? 8'd1 : i_cfg.retry_limit;
    assign mandatory  = 32'(r_pos) < 32'(minl_eff);
    assign tries_n    = {1'b0, r_tries} + 9'd1;
    assign retry_more = tries_n < {1'b0, retry_eff};
    assign is_term    = (r_sym == '0);
    assign sym_final  = is_term ? SW'(1) : r_sym;
    assign pos_n      = r_pos + PW'(1);
    assign name_full  = (pos_n == maxl_eff);
    assign can_push   = (r_pos == '0) || slot_free;
    assign pend_ext   = {5'b0, r_pend};

    // table write on a write item whose row and column lie inside the table
    assign wr_in_range = (32'(i_in.row) < SYMBOLS) && (32'(i_in.column) < SYMBOLS);
    assign o_tab_we    = in_accept && (i_in.operation == OP_WRITE) && wr_in_range;
    assign o_tab_waddr = AW'(AW'(i_in.row) * AW'(SYMBOLS)) + AW'(i_in.column);
    assign o_tab_wdata = i_in.weight;

    // row walk reads, one entry ahead of the running sum
    assign o_tab_re    = (r_state == ST_ADDR) ||
                         ((r_state == ST_WALK) && (r_k != SW'(SYMBOLS - 1)));
    assign o_tab_raddr = (r_state == ST_ADDR) ? r_base : (r_base + AW'(r_k) + AW'(1));

    assign o_rng_step  = (r_state == ST_DRAW);
    assign o_in_stall  = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_in.operation == OP_GENERATE)) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: n_state = ST_ADDR;
            ST_ADDR: n_state = ST_WALK;
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (mandatory) begin
                    n_state = (is_term && retry_more) ? ST_DRAW : ST_PUSH;
                end else begin
                    n_state = is_term ? ST_FLUSH : ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (can_push) begin
                    n_state = name_full ? ST_FLUSH : ST_DRAW;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_base      = r_base;
        n_prev      = r_prev;
        n_k         = r_k;
        n_sum       = r_sum;
        n_sym       = r_sym;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_tries     = r_tries;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                n_prev  = '0;
                n_pos   = '0;
                n_tries = '0;
            end
            ST_DRAW: begin
                n_base = AW'(AW'(r_prev) * AW'(SYMBOLS));
                n_k    = '0;
                n_sum  = '0;
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_sym = r_k;
                end else begin
                    n_k   = r_k + SW'(1);
                    n_sum = sum_n;
                end
            end
            ST_DECIDE: begin
                if (mandatory) begin
                    if (is_term && retry_more) begin
                        n_tries = tries_n[7:0];
                    end else begin
                        n_sym = sym_final;
                    end
                end
            end
            ST_PUSH: begin
                if (can_push) begin
                    if (r_pos != '0) begin
                        n_out_valid = 1'b1;
                        n_out       = '{letter: pend_ext[4:0], last: 1'b0};
                    end
                    n_pend  = r_sym;
                    n_prev  = r_sym;
                    n_pos   = pos_n;
                    n_tries = '0;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{letter: pend_ext[4:0], last: 1'b1};
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_prev  <= n_prev;
        r_k     <= n_k;
        r_sum   <= n_sum;
        r_sym   <= n_sym;
        r_pend  <= n_pend;
        r_pos   <= n_pos;
        r_tries <= n_tries;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/bigram_name_sampler.sv
// ----------------------------------------------------------------------------
// bigram_name_sampler
// markov name generator over a table of letter-pair weights
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid/o_in_stall   t_in_item (operation, row, column, weight)
//  out      output     o_out_valid/i_out_stall t_out_item (letter, last)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  each draw walks its row through the single table read port
//  a name runs from the accept in idle through its draws, including retries, to the flush
//  no clearing pass after reset, table entries are undefined until written
//  a letter push and the flush wait while the result register is stalled
//  the result register frees the sequencer while the last letter waits on stall
// ----------------------------------------------------------------------------
module bigram_name_sampler
    import bns_pkg::*;
#(
    parameter int SYMBOLS         = SYMBOLS_DEF,
    parameter int MAX_NAME_LENGTH = MAX_NAME_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    localparam int AW = $clog2(SYMBOLS * SYMBOLS);

    t_cfg             r_cfg;
    logic             tab_we;
    logic [AW-1:0]    tab_waddr;
    logic [7:0]       tab_wdata;
    logic             tab_re;
    logic [AW-1:0]    tab_raddr;
    logic [7:0]       tab_rdata;
    logic             rng_step;
    logic [RND_W-1:0] rng_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{min_length: MIN_LENGTH_RST, max_length: MAX_LENGTH_RST,
                       retry_limit: RETRY_LIMIT_RST};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_LENGTH:  r_cfg.min_length  <= i_cfg_data[3:0];
                CFG_MAX_LENGTH:  r_cfg.max_length  <= i_cfg_data[3:0];
                CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    bns_table #(
        .SYMBOLS (SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    bns_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (rng_step),
        .o_value (rng_value)
    );

    bns_seq #(
        .SYMBOLS         (SYMBOLS),
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_tab_we    (tab_we),
        .o_tab_waddr (tab_waddr),
        .o_tab_wdata (tab_wdata),
        .o_tab_re    (tab_re),
        .o_tab_raddr (tab_raddr),
        .i_tab_rdata (tab_rdata),
        .o_rng_step  (rng_step),
        .i_rng_value (rng_value)
    );

endmodule

>>> sim/bigram_name_sampler_tb.sv
// ----------------------------------------------------------------------------
// bigram_name_sampler_tb
// self-checking bench for the bigram name sampler: the whole weight table is
// loaded first, then directed and random weight writes and name requests run
// under several length and retry settings; every letter transfer is compared
// with a software prediction of the xorshift draw and the row walk
// ----------------------------------------------------------------------------
class name_scoreboard;
    localparam int SYM     = bns_pkg::SYMBOLS_DEF;
    localparam int LONGEST = bns_pkg::MAX_NAME_LENGTH_DEF;

    bit [7:0]            weights [SYM*SYM];
    bit [3:0]            min_length;
    bit [3:0]            max_length;
    bit [7:0]            retry_limit;
    bit [7:0]            rng;
    bit [7:0]            draw_count;
    bns_pkg::t_out_item  letters_due [$];
    int                  errors;
    int                  names;
    int                  letters;
    int                  forced;
    int                  early_ends;

    function new();
        foreach (weights[i]) weights[i] = 8'd0;
        min_length  = bns_pkg::MIN_LENGTH_RST;
        max_length  = bns_pkg::MAX_LENGTH_RST;
        retry_limit = bns_pkg::RETRY_LIMIT_RST;
        rng         = bns_pkg::RNG_STATE_RST;
        draw_count  = 8'd0;
        errors      = 0;
        names       = 0;
        letters     = 0;
        forced      = 0;
        early_ends  = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] data);
        case (index)
            bns_pkg::CFG_MIN_LENGTH:  min_length  = data[3:0];
            bns_pkg::CFG_MAX_LENGTH:  max_length  = data[3:0];
            bns_pkg::CFG_RETRY_LIMIT: retry_limit = data;
            default: ;
        endcase
    endfunction

    function bit [7:0] advance_rng();
        bit [7:0] s;
        draw_count = draw_count + 8'd1;
        s = rng;
        s = s ^ (s << 1);
        s = s ^ (s >> 1);
        s = s ^ (s << 2);
        s = s ^ draw_count;
        if (s == 8'd0) s = 8'd1;
        rng = s;
        return s;
    endfunction

    function int pick_next(int prev);
        bit [15:0] r;
        bit [15:0] total;
        r = {8'd0, advance_rng()};
        total = 16'd0;
        for (int k = 0; k < SYM; k++) begin
            total = total + weights[prev*SYM + k];
            if (r < total) return k;
        end
        return SYM - 1;
    endfunction

    function void note_input(bns_pkg::t_in_item item);
        int                 maxl;
        int                 minl;
        int                 prev;
        int                 sym;
        int                 tries;
        int                 len;
        int                 spelled [LONGEST];
        bns_pkg::t_out_item want;
        if (item.operation == bns_pkg::OP_WRITE) begin
            if (item.row < SYM && item.column < SYM)
                weights[item.row*SYM + item.column] = item.weight;
            return;
        end
        maxl = (max_length == 4'd0) ? 1 : int'(max_length);
        if (maxl > LONGEST) maxl = LONGEST;
        minl = (min_length == 4'd0) ? 1 : int'(min_length);
        prev = 0;
        len  = 0;
        for (int pos = 0; pos < maxl; pos++) begin
            if (pos < minl) begin
                tries = 0;
                do begin
                    sym = pick_next(prev);
                    tries++;
                end while (sym == 0 && tries < retry_limit);
                if (sym == 0) begin
                    sym = 1;
                    forced++;
                end
            end else begin
                sym = pick_next(prev);
                if (sym == 0) begin
                    early_ends++;
                    break;
                end
            end
            spelled[len] = sym;
            len++;
            prev = sym;
        end
        names++;
        for (int k = 0; k < len; k++) begin
            want.letter = spelled[k][4:0];
            want.last   = (k == len - 1);
            letters_due.push_back(want);
        end
    endfunction

    function void check_letter(bns_pkg::t_out_item got);
        bns_pkg::t_out_item want;
        if (letters_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected letter transfer, expected none, actual letter %0d last %0b",
                     $time, got.letter, got.last);
            return;
        end
        want = letters_due.pop_front();
        letters++;
        if (got.letter !== want.letter) begin
            errors++;
            $display("%0t: letter mismatch, expected %0d, actual %0d",
                     $time, want.letter, got.letter);
        end
        if (got.last !== want.last) begin
            errors++;
            $display("%0t: last flag mismatch, expected %0b, actual %0b",
                     $time, want.last, got.last);
        end
    endfunction
endclass

module bigram_name_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bns_pkg::*;

    localparam int         SYM           = SYMBOLS_DEF;
    localparam int         LIMIT_CYCLES  = 2_000_000;
    localparam int         SETTLE        = 40;
    localparam int         PHASE_ITEMS   = 60;
    localparam int         RANDOM_PHASES = 8;
    localparam int         SAFE_RETRY    = 16;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    typedef enum int {
        ROW_SPREAD,
        ROW_SPARSE,
        ROW_STOP_HEAVY,
        ROW_EMPTY
    } t_row_shape;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;

    name_scoreboard board;
    bit             calm      = 1'b0;
    bit             big_retry = 1'b1;
    bit             risky [SYM];
    int             cycles    = 0;
    int             settings  = 0;

    bigram_name_sampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_letter(o_out);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send(t_in_item item);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 22) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(item);
    endtask

    task automatic write_weight(int row, int column, logic [7:0] weight);
        t_in_item item;
        item.operation = OP_WRITE;
        item.row       = row[4:0];
        item.column    = column[4:0];
        item.weight    = weight;
        send(item);
    endtask

    task automatic request_name();
        t_in_item item;
        item           = t_in_item'($urandom);
        item.operation = OP_GENERATE;
        send(item);
    endtask

    task automatic load_row(int row, t_row_shape shape);
        logic [7:0] w;
        for (int col = 0; col < SYM; col++) begin
            case (shape)
                ROW_SPREAD:     w = random_weight();
                ROW_SPARSE:     w = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
                ROW_STOP_HEAVY: w = (col == 0) ? 8'($urandom_range(200, 255))
                                               : 8'($urandom_range(0, 8));
                default:        w = 8'd0;
            endcase
            write_weight(row, col, w);
        end
        risky[row] = (shape == ROW_SPARSE || shape == ROW_STOP_HEAVY);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.letters_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_register(index, data);
    endtask

    task automatic configure(logic [3:0] min_len, logic [3:0] max_len, logic [7:0] retries);
        write_reg(CFG_UNUSED, 8'($urandom));
        write_reg(CFG_MIN_LENGTH, {4'($urandom), min_len});
        write_reg(CFG_MAX_LENGTH, {4'($urandom), max_len});
        write_reg(CFG_RETRY_LIMIT, retries);
        i_cfg_valid <= 1'b0;
        big_retry = retries > SAFE_RETRY;
        settings++;
        if (big_retry) begin
            for (int r = 0; r < SYM; r++)
                if (risky[r]) load_row(r, ROW_SPREAD);
        end
    endtask

    initial begin
        int         items;
        int         pick;
        logic [3:0] min_len;
        logic [3:0] max_len;
        logic [7:0] retries;
        t_row_shape shape;
        board = new();
        foreach (risky[r]) risky[r] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SYM; r++) load_row(r, ROW_SPREAD);

        // writes outside the table are dropped; the corner entry is then rewritten in range
        write_weight(31, 0, 8'd255);
        write_weight(0, 31, 8'd255);
        write_weight(27, 27, 8'h55);
        write_weight(26, 26, 8'd0);
        write_weight(26, 26, 8'd255);
        repeat (3) request_name();
        // terminator dominates row 0 under the largest retry limit
        write_weight(0, 0, 8'd255);
        request_name();
        write_weight(0, 0, 8'd0);
        request_name();
        drain();
        configure(4'd0, 4'd0, 8'd0);
        repeat (3) request_name();
        drain();
        configure(4'd15, 4'd15, 8'd255);
        repeat (2) request_name();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p)
                0: begin min_len = 4'd1;  max_len = 4'd8;  retries = 8'd1; end
                1: begin min_len = 4'd8;  max_len = 4'd8;  retries = 8'd3; end
                2: begin min_len = 4'd2;  max_len = 4'd5;  retries = 8'd0; end
                3: begin min_len = 4'd15; max_len = 4'd1;  retries = 8'd16; end
                default: begin
                    min_len = 4'($urandom_range(0, 15));
                    max_len = 4'($urandom_range(0, 15));
                    retries = $urandom_range(0, 1) ? 8'($urandom_range(0, SAFE_RETRY))
                                                   : 8'($urandom_range(0, 255));
                end
            endcase
            calm = (p == 2);
            configure(min_len, max_len, retries);
            items = 0;
            while (items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    request_name();
                    items++;
                end else if (pick < 88) begin
                    write_weight($urandom_range(0, 31),
                                 big_retry ? $urandom_range(1, 31) : $urandom_range(0, 31),
                                 random_weight());
                    items++;
                end else if (pick < 92) begin
                    drain();
                end else begin
                    shape = t_row_shape'($urandom_range(0, 3));
                    if (big_retry && (shape == ROW_SPARSE || shape == ROW_STOP_HEAVY))
                        shape = ROW_SPREAD;
                    load_row($urandom_range(0, SYM - 1), shape);
                    items += SYM;
                end
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (board.letters_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        board.errors += board.letters_due.size();
        $display("covered %0d names and %0d letters under %0d register settings",
                 board.names, board.letters, settings);
        $display("%0d letters forced after retries, %0d names cut short by a terminator",
                 board.forced, board.early_ends);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
